/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/sem_pkg.sv */
// ---------------------------------------------------------------------------
// sem_pkg
// Types, widths and register codes of the Sobel edge magnitude block.
// ---------------------------------------------------------------------------
package sem_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam int PIXEL_W         = 8;
    localparam int IMAGE_WIDTH_W   = 11;
    localparam int IMAGE_HEIGHT_W  = 12;
    localparam int EDGE_W          = 8;
    localparam int CENTRE_COLUMN_W = 10;
    localparam int CENTRE_ROW_W    = 12;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_WIDTH  = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_HEIGHT = 4'h4;
    localparam logic [APB_ADDR_W-1:0] ADDR_NORM_SELECT  = 4'h8;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
    localparam logic                      NORM_L2          = 1'b0;
    localparam logic                      NORM_L1          = 1'b1;
    localparam logic                      NORM_SELECT_RST  = NORM_L1;

    // Absolute gradient is at most 1020, the sum of squares stays below 2^21,
    // and both magnitudes (L1 sum, rounded root) stay below 2^11.
    localparam int SGRAD_W = 12;
    localparam int GRAD_W  = 10;
    localparam int SUMSQ_W = 21;
    localparam int MAG_W   = 11;

    localparam logic [EDGE_W-1:0] EDGE_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAD,
        ST_MAG,
        ST_ROOT,
        ST_EMIT
    } sem_state_t;

endpackage

/* hw/rtl/sobel_edge_magnitude.sv */
// Flow: a taken pixel is registered with its line store read, then the
// gradient registers load and the line store is written back; border pixels
// give no output. Interior ones go on to mag_reg (L1 sum, or the rounded root
// in L2 mode) and then to the output register; only one pixel is in flight.
// Reset: counters cleared, registers at 640 x 480 and L1 mode; the line store
// is not cleared: entries read before they are written feed only border items.
// ---------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over a raster pixel stream, with
// the two previous rows kept in one synchronous line store.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PIXEL_W-1:0]         pixel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [EDGE_W-1:0]          edge_value,
    output logic [CENTRE_COLUMN_W-1:0] centre_column,
    output logic [CENTRE_ROW_W-1:0]    centre_row,
    output logic                       frame_last
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WCMP_W  = (CW + 1 > IMAGE_WIDTH_W) ? CW + 1 : IMAGE_WIDTH_W;
    localparam int HCMP_W  = IMAGE_HEIGHT_W + 1;
    localparam int LINE_W  = 2 * PIXEL_W;
    localparam int MAGQ_W  = MAG_W - 2;

    // Configuration registers.
    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;
    logic                      norm_select_reg;
    logic                      cfg_wr;

    // Control.
    sem_state_t state_reg;
    sem_state_t state_next;
    logic       in_accept;
    logic       mem_rd;
    logic       grad_en;
    logic       sqrt_start;
    logic       mag_l1_load;
    logic       mag_root_load;
    logic       out_load;
    logic       out_free;

    // Counters and window.
    logic [CW-1:0]             col_reg;
    logic [IMAGE_HEIGHT_W-1:0] row_reg;
    logic [PIXEL_W-1:0]        win_reg [6];
    logic [PIXEL_W-1:0]        pixel_reg;
    logic [WCMP_W-1:0]         w_cfg;
    logic [WCMP_W-1:0]         w_max;
    logic [WCMP_W-1:0]         w_eff;
    logic [IMAGE_HEIGHT_W-1:0] h_eff;
    logic                      col_last;
    logic                      row_last;
    logic                      interior;

    // Line store: older row in the upper byte, newer row in the lower byte.
    logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]  line_rd_reg;
    logic [PIXEL_W-1:0] top_pix;
    logic [PIXEL_W-1:0] mid_pix;

    // Gradient and magnitude.
    logic signed [SGRAD_W-1:0] p00;
    logic signed [SGRAD_W-1:0] p10;
    logic signed [SGRAD_W-1:0] p20;
    logic signed [SGRAD_W-1:0] p01;
    logic signed [SGRAD_W-1:0] p21;
    logic signed [SGRAD_W-1:0] p02;
    logic signed [SGRAD_W-1:0] p12;
    logic signed [SGRAD_W-1:0] p22;
    logic signed [SGRAD_W-1:0] gx;
    logic signed [SGRAD_W-1:0] gy;
    logic signed [SGRAD_W-1:0] gx_abs;
    logic signed [SGRAD_W-1:0] gy_abs;
    logic [GRAD_W-1:0]         ax_reg;
    logic [GRAD_W-1:0]         ay_reg;
    logic [2*GRAD_W-1:0]       ax_sq;
    logic [2*GRAD_W-1:0]       ay_sq;
    logic [SUMSQ_W-1:0]        sum_sq;
    logic [MAG_W-1:0]          mag_reg;
    logic [MAGQ_W-1:0]         mag_q;
    logic [CW-1:0]             ccol_reg;
    logic [IMAGE_HEIGHT_W-1:0] crow_reg;
    logic                      flast_reg;
    logic                      sqrt_busy;
    logic                      sqrt_done;
    logic [MAG_W-1:0]          sqrt_root;

    // Output register.
    logic                       out_valid_reg;
    logic [EDGE_W-1:0]          edge_value_reg;
    logic [CENTRE_COLUMN_W-1:0] centre_column_reg;
    logic [CENTRE_ROW_W-1:0]    centre_row_reg;
    logic                       frame_last_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            norm_select_reg  <= NORM_SELECT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_IMAGE_WIDTH:  image_width_reg  <= pwdata[IMAGE_WIDTH_W-1:0];
                ADDR_IMAGE_HEIGHT: image_height_reg <= pwdata[IMAGE_HEIGHT_W-1:0];
                ADDR_NORM_SELECT:  norm_select_reg  <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            ADDR_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            ADDR_NORM_SELECT:  prdata = APB_DATA_W'(norm_select_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame geometry
    // ------------------------------------------------------------------
    assign w_cfg = WCMP_W'(image_width_reg);
    assign w_max = WCMP_W'(MAX_WIDTH);
    assign w_eff = (w_cfg > w_max) ? w_max : ((w_cfg == '0) ? WCMP_W'(1) : w_cfg);
    assign h_eff = (image_height_reg == '0) ? IMAGE_HEIGHT_W'(1) : image_height_reg;

    assign col_last = (WCMP_W'(col_reg) + WCMP_W'(1)) >= w_eff;
    assign row_last = (HCMP_W'(row_reg) + HCMP_W'(1)) >= HCMP_W'(h_eff);
    assign interior = (col_reg >= CW'(2)) && (row_reg >= IMAGE_HEIGHT_W'(2));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD:
            begin
                state_next = interior ? ST_MAG : ST_IDLE;
            end
            ST_MAG:
            begin
                state_next = (norm_select_reg == NORM_L1) ? ST_EMIT : ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        mem_rd        = 1'b0;
        grad_en       = 1'b0;
        sqrt_start    = 1'b0;
        mag_l1_load   = 1'b0;
        mag_root_load = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_rd   = in_valid;
            end
            ST_GRAD:
            begin
                grad_en = 1'b1;
            end
            ST_MAG:
            begin
                mag_l1_load = (norm_select_reg == NORM_L1);
                sqrt_start  = (norm_select_reg == NORM_L2);
            end
            ST_ROOT:
            begin
                mag_root_load = sqrt_done;
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read when the item is taken, written back in the following
    // cycle at the same column. Only one item is in flight, so no forwarding.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (grad_en)
        begin
            line_mem[col_reg] <= {mid_pix, pixel_reg};
        end
        if (mem_rd)
        begin
            line_rd_reg <= line_mem[col_reg];
        end
    end

    assign top_pix = line_rd_reg[LINE_W-1:PIXEL_W];
    assign mid_pix = line_rd_reg[PIXEL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pixel_reg <= pixel;
        end
    end

    // ------------------------------------------------------------------
    // Counters and window
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_IMAGE_WIDTH || paddr == ADDR_IMAGE_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (grad_en)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + IMAGE_HEIGHT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (grad_en)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_pix;
            win_reg[4] <= mid_pix;
            win_reg[5] <= pixel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gradient
    // ------------------------------------------------------------------
    assign p00 = $signed(SGRAD_W'(win_reg[0]));
    assign p10 = $signed(SGRAD_W'(win_reg[1]));
    assign p20 = $signed(SGRAD_W'(win_reg[2]));
    assign p01 = $signed(SGRAD_W'(win_reg[3]));
    assign p21 = $signed(SGRAD_W'(win_reg[5]));
    assign p02 = $signed(SGRAD_W'(top_pix));
    assign p12 = $signed(SGRAD_W'(mid_pix));
    assign p22 = $signed(SGRAD_W'(pixel_reg));

    assign gx = (p02 - p00) + ((p12 - p10) <<< 1) + (p22 - p20);
    assign gy = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);

    assign gx_abs = gx[SGRAD_W-1] ? -gx : gx;
    assign gy_abs = gy[SGRAD_W-1] ? -gy : gy;

    always_ff @(posedge clk)
    begin
        if (grad_en)
        begin
            ax_reg    <= gx_abs[GRAD_W-1:0];
            ay_reg    <= gy_abs[GRAD_W-1:0];
            ccol_reg  <= col_reg - CW'(1);
            crow_reg  <= row_reg - IMAGE_HEIGHT_W'(1);
            flast_reg <= col_last && row_last;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude
    // ------------------------------------------------------------------
    assign ax_sq  = ax_reg * ax_reg;
    assign ay_sq  = ay_reg * ay_reg;
    assign sum_sq = SUMSQ_W'(ax_sq) + SUMSQ_W'(ay_sq);

    sem_isqrt u_isqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sum_sq),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_ff @(posedge clk)
    begin
        if (mag_l1_load)
        begin
            mag_reg <= MAG_W'(ax_reg) + MAG_W'(ay_reg);
        end
        else if (mag_root_load)
        begin
            mag_reg <= sqrt_root;
        end
    end

    // Scaling by 255/1020 is a shift by two.
    assign mag_q = mag_reg[MAG_W-1:2];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            edge_value_reg    <= (mag_q > MAGQ_W'(EDGE_MAX)) ? EDGE_MAX : mag_q[EDGE_W-1:0];
            centre_column_reg <= CENTRE_COLUMN_W'(ccol_reg);
            centre_row_reg    <= crow_reg;
            frame_last_reg    <= flast_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_value    = edge_value_reg;
    assign centre_column = centre_column_reg;
    assign centre_row    = centre_row_reg;
    assign frame_last    = frame_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_take_then_grad, clk, rst_n, in_accept, state_reg == ST_GRAD)
    `ASSERT_IMPLIES(a_root_only_in_root, clk, rst_n, sqrt_busy, state_reg == ST_ROOT)
    `ASSERT_IMPLIES(a_col_in_range, clk, rst_n, 1'b1, WCMP_W'(col_reg) < w_eff)
    `ASSERT_IMPLIES(a_row_in_range, clk, rst_n, 1'b1, row_reg < h_eff)

endmodule

/* hw/rtl/sem_isqrt.sv */
// ---------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, one result bit per cycle, with rounding
// of the root to the nearest integer.
// ---------------------------------------------------------------------------
module sem_isqrt
    import sem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUMSQ_W-1:0] operand,
    output logic               busy,
    output logic               done,
    output logic [MAG_W-1:0]   root
);

    localparam int STEPS = (SUMSQ_W + 1) / 2;
    localparam int BIT_W = 2 * STEPS;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [BIT_W-1:0] rem_reg;
    logic [BIT_W-1:0] rem_next;
    logic [BIT_W-1:0] acc_reg;
    logic [BIT_W-1:0] acc_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [BIT_W-1:0] trial;
    logic             take;
    logic [MAG_W-1:0] floor_root;
    logic             round_up;

    assign trial = acc_reg + bit_reg;
    assign take  = (rem_reg >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = BIT_W'(operand);
            acc_next  = '0;
            bit_next  = BIT_W'(1) << (BIT_W - 2);
        end
        else if (busy_reg)
        begin
            rem_next = take ? (rem_reg - trial) : rem_reg;
            acc_next = take ? ((acc_reg >> 1) + bit_reg) : (acc_reg >> 1);
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
    end

    // The remainder left over is s - q*q; rounding up when it exceeds q
    // is round half away from zero.
    assign floor_root = acc_reg[MAG_W-1:0];
    assign round_up   = (rem_reg > BIT_W'(floor_root));
    assign root       = floor_root + MAG_W'(round_up);
    assign busy       = busy_reg;
    assign done       = done_reg;

endmodule
